@@ rtl/torus_signed_distance_assert.svh @@
// ---------------------------------------------------------------------------
// Torus signed distance assertion macros
// Concurrent assertion wrappers shared by the torus distance RTL.
// ---------------------------------------------------------------------------
`ifndef TORUS_SIGNED_DISTANCE_ASSERT_SVH
`define TORUS_SIGNED_DISTANCE_ASSERT_SVH

`ifndef ASSERT_OFF

// Same-cycle implication.
`define TSD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("torus_signed_distance: assertion failed");

// Next-cycle implication.
`define TSD_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("torus_signed_distance: assertion failed");

`else

`define TSD_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define TSD_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

@@ rtl/tsd_pkg.sv @@
// ---------------------------------------------------------------------------
// Torus signed distance package
// Widths, reset values, register indexes and the root cell state type.
// ---------------------------------------------------------------------------
package tsd_pkg;

    // Field widths.
    localparam int unsigned COORD_W  = 32;
    localparam int unsigned RADIUS_W = 31;
    localparam int unsigned DIST_W   = 32;

    // Square root datapath: 64-bit radicand, 32-bit root, one bit per cell.
    localparam int unsigned RAD_W      = 64;
    localparam int unsigned ROOT_W     = 32;
    localparam int unsigned ROOT_STEPS = RAD_W / 2;

    // Configuration port.
    localparam int unsigned CFG_IDX_W = 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RING_RADIUS = 1'b0,
        CFG_TUBE_RADIUS = 1'b1
    } t_cfg_index;

    localparam logic [RADIUS_W-1:0] RING_RADIUS_RESET = 31'd65536;
    localparam logic [RADIUS_W-1:0] TUBE_RADIUS_RESET = 31'd32768;

    // State handed from one root cell to the next.
    typedef struct packed {
        logic             valid;
        logic [RAD_W-1:0] rem;
        logic [RAD_W-1:0] res;
    } t_root_state;

endpackage

@@ rtl/tsd_root_cell.sv @@
// ---------------------------------------------------------------------------
// Torus signed distance square root cell
// One restoring step of the integer square root, registered.
// ---------------------------------------------------------------------------
module tsd_root_cell #(
    parameter int unsigned STEP = 0
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  tsd_pkg::t_root_state i_state,
    output tsd_pkg::t_root_state o_state
);

    localparam int unsigned W     = tsd_pkg::RAD_W;
    localparam int unsigned SHIFT = W - 2 - 2 * STEP;
    localparam logic [W-1:0] BIT  = {{(W-1){1'b0}}, 1'b1} << SHIFT;

    tsd_pkg::t_root_state r_state;
    tsd_pkg::t_root_state n_state;
    logic [W-1:0]         w_trial;
    logic                 w_take;

    // Try to set this root bit; keep it when the remainder allows.
    always_comb begin
        w_trial       = i_state.res + BIT;
        w_take        = (i_state.rem >= w_trial);
        n_state.valid = i_state.valid;
        if (w_take) begin
            n_state.rem = i_state.rem - w_trial;
            n_state.res = (i_state.res >> 1) + BIT;
        end else begin
            n_state.rem = i_state.rem;
            n_state.res = i_state.res >> 1;
        end
    end

    // Only the valid flag is cleared on reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.valid <= 1'b0;
        end else if (i_en) begin
            r_state <= n_state;
        end
    end

    assign o_state = r_state;

endmodule

@@ rtl/tsd_root_chain.sv @@
// ---------------------------------------------------------------------------
// Torus signed distance square root chain
// A row of root cells giving the truncated square root of a 64-bit value.
// ---------------------------------------------------------------------------
`include "torus_signed_distance_assert.svh"

module tsd_root_chain (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_valid,
    input  logic [tsd_pkg::RAD_W-1:0]    i_radicand,
    output logic                         o_valid,
    output logic [tsd_pkg::ROOT_W-1:0]   o_root
);

    localparam int unsigned STEPS = tsd_pkg::ROOT_STEPS;

    tsd_pkg::t_root_state w_state [0:STEPS];

    // The chain starts with the full radicand as remainder and an empty root.
    assign w_state[0] = '{valid: i_valid, rem: i_radicand, res: '0};

    // One cell per root bit, most significant first.
    for (genvar g = 0; g < STEPS; g++) begin : g_cell
        tsd_root_cell #(
            .STEP (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (i_en),
            .i_state (w_state[g]),
            .o_state (w_state[g+1])
        );
    end

    assign o_valid = w_state[STEPS].valid;
    assign o_root  = w_state[STEPS].res[tsd_pkg::ROOT_W-1:0];

    // The finished root fits its width and leaves a remainder of at most twice it.
    `TSD_ASSERT_IMP(a_root_fits, i_clk, i_rst_n, o_valid,
        w_state[STEPS].res[tsd_pkg::RAD_W-1:tsd_pkg::ROOT_W] == '0)
    `TSD_ASSERT_IMP(a_rem_bound, i_clk, i_rst_n, o_valid,
        w_state[STEPS].rem <= (w_state[STEPS].res << 1))
    `TSD_ASSERT_NXT(a_frozen_hold, i_clk, i_rst_n, !i_en, $stable(o_valid))

endmodule

@@ rtl/torus_signed_distance.sv @@
// ---------------------------------------------------------------------------
// Torus signed distance: Q16.16 distance from a point to a z-axis torus.
// Throughput: one point per cycle while o_stall is low; the root chains take
// one root bit per cell.
// Reset: synchronous, active low; clears the pipeline and loads default radii.
// ---------------------------------------------------------------------------
`include "torus_signed_distance_assert.svh"

module torus_signed_distance (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Point input channel
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic signed [tsd_pkg::COORD_W-1:0]  i_pos_x,
    input  logic signed [tsd_pkg::COORD_W-1:0]  i_pos_y,
    input  logic signed [tsd_pkg::COORD_W-1:0]  i_pos_z,
    // Distance output channel
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic signed [tsd_pkg::DIST_W-1:0]   o_distance,
    // Configuration write channel
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [tsd_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [tsd_pkg::RADIUS_W-1:0]        i_cfg_data
);

    localparam int unsigned CW    = tsd_pkg::COORD_W;
    localparam int unsigned RW    = tsd_pkg::RAD_W;
    localparam int unsigned QW    = tsd_pkg::ROOT_W;
    localparam int unsigned DW    = tsd_pkg::DIST_W;
    localparam int unsigned STEPS = tsd_pkg::ROOT_STEPS;

    function automatic logic [CW-1:0] magnitude(input logic signed [CW-1:0] v);
        logic [CW-1:0] neg;
        neg = CW'(0) - CW'(v);
        return v[CW-1] ? neg : CW'(v);
    endfunction

    logic                            w_en;
    logic                            w_push;
    logic                            w_pop;

    logic [tsd_pkg::RADIUS_W-1:0]    r_ring_radius;
    logic [tsd_pkg::RADIUS_W-1:0]    r_tube_radius;

    logic                            r_s0_valid;
    logic [CW-1:0]                   r_s0_ax, r_s0_ay, r_s0_az;
    logic                            r_s1_valid;
    logic [RW-1:0]                   r_s1_sqx, r_s1_sqy;
    logic [CW-1:0]                   r_s1_az;
    logic                            r_s2_valid;
    logic [RW-1:0]                   r_s2_plane;
    logic [CW-1:0]                   r_zd [0:STEPS+1];

    logic                            w_c1_valid;
    logic [QW-1:0]                   w_c1_root;
    logic [QW-1:0]                   w_ring_ext;
    logic [QW-1:0]                   n_s3_qmag;

    logic                            r_s3_valid;
    logic [QW-1:0]                   r_s3_qmag;
    logic [CW-1:0]                   r_s3_az;
    logic                            r_s4_valid;
    logic [RW-1:0]                   r_s4_sqq, r_s4_sqz;
    logic                            r_s5_valid;
    logic [RW-1:0]                   r_s5_sum;

    logic                            w_c2_valid;
    logic [QW-1:0]                   w_c2_len;
    logic signed [QW+1:0]            w_diff;
    logic [DW-1:0]                   n_s6_dist;

    logic                            r_s6_valid;
    logic [DW-1:0]                   r_s6_dist;
    logic                            r_out_valid;
    logic [DW-1:0]                   r_out_dist;
    logic                            r_skid_valid;
    logic [DW-1:0]                   r_skid_dist;

    // The whole pipeline moves together while the skid register is free.
    assign w_en        = !r_skid_valid;
    assign o_stall     = r_skid_valid;
    assign o_cfg_ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ring_radius <= tsd_pkg::RING_RADIUS_RESET;
            r_tube_radius <= tsd_pkg::TUBE_RADIUS_RESET;
        end else if (i_cfg_valid) begin
            unique case (tsd_pkg::t_cfg_index'(i_cfg_index))
                tsd_pkg::CFG_RING_RADIUS: r_ring_radius <= i_cfg_data;
                tsd_pkg::CFG_TUBE_RADIUS: r_tube_radius <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Valid flags for the stages outside the root chains.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
            r_s4_valid <= 1'b0;
            r_s5_valid <= 1'b0;
            r_s6_valid <= 1'b0;
        end else if (w_en) begin
            r_s0_valid <= i_valid;
            r_s1_valid <= r_s0_valid;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= w_c1_valid;
            r_s4_valid <= r_s3_valid;
            r_s5_valid <= r_s4_valid;
            r_s6_valid <= w_c2_valid;
        end
    end

    // Front end: magnitudes, squares and the squared radius in the ring plane.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s0_ax    <= magnitude(i_pos_x);
            r_s0_ay    <= magnitude(i_pos_y);
            r_s0_az    <= magnitude(i_pos_z);
            r_s1_sqx   <= RW'(r_s0_ax) * RW'(r_s0_ax);
            r_s1_sqy   <= RW'(r_s0_ay) * RW'(r_s0_ay);
            r_s1_az    <= r_s0_az;
            r_s2_plane <= r_s1_sqx + r_s1_sqy;
        end
    end

    // The z magnitude travels beside the plane sum and the first root chain.
    always_comb r_zd[0] = r_s1_az;

    for (genvar g = 0; g <= STEPS; g++) begin : g_zdelay
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_zd[g+1] <= r_zd[g];
            end
        end
    end

    tsd_root_chain u_plane_root (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (w_en),
        .i_valid    (r_s2_valid),
        .i_radicand (r_s2_plane),
        .o_valid    (w_c1_valid),
        .o_root     (w_c1_root)
    );

    // Distance from the tube center line in the ring plane, as a magnitude.
    always_comb begin
        w_ring_ext = QW'(r_ring_radius);
        if (w_c1_root >= w_ring_ext) begin
            n_s3_qmag = w_c1_root - w_ring_ext;
        end else begin
            n_s3_qmag = w_ring_ext - w_c1_root;
        end
    end

    // Middle: squares of the offset and z, then their sum.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s3_qmag <= n_s3_qmag;
            r_s3_az   <= r_zd[STEPS+1];
            r_s4_sqq  <= RW'(r_s3_qmag) * RW'(r_s3_qmag);
            r_s4_sqz  <= RW'(r_s3_az) * RW'(r_s3_az);
            r_s5_sum  <= r_s4_sqq + r_s4_sqz;
        end
    end

    tsd_root_chain u_tube_root (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (w_en),
        .i_valid    (r_s5_valid),
        .i_radicand (r_s5_sum),
        .o_valid    (w_c2_valid),
        .o_root     (w_c2_len)
    );

    // Subtract the tube radius and saturate to the output range.
    always_comb begin
        w_diff = $signed({2'b00, w_c2_len}) - $signed({3'b000, r_tube_radius});
        if (!w_diff[QW+1] && (w_diff[QW:DW-1] != 2'b00)) begin
            n_s6_dist = {1'b0, {(DW-1){1'b1}}};
        end else if (w_diff[QW+1] && (w_diff[QW:DW-1] != 2'b11)) begin
            n_s6_dist = {1'b1, {(DW-1){1'b0}}};
        end else begin
            n_s6_dist = w_diff[DW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s6_dist <= n_s6_dist;
        end
    end

    // Output register with a skid register behind it.
    assign w_push = w_en && r_s6_valid;
    assign w_pop  = r_out_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || w_pop) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_out_dist   <= r_skid_dist;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= w_push;
                if (w_push) begin
                    r_out_dist <= r_s6_dist;
                end
            end
        end else if (w_push) begin
            r_skid_valid <= 1'b1;
            r_skid_dist  <= r_s6_dist;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_distance = r_out_dist;

    // Skid register only fills behind a held result.
    `TSD_ASSERT_IMP(a_skid_behind_out, i_clk, i_rst_n, r_skid_valid, r_out_valid)
    `TSD_ASSERT_NXT(a_skid_catches, i_clk, i_rst_n, r_out_valid && i_stall && w_push,
        r_skid_valid)
    `TSD_ASSERT_IMP(a_skid_cause, i_clk, i_rst_n, $rose(r_skid_valid),
        $past(r_out_valid && i_stall))

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Torus signed distance testbench
// Drives points through the distance pipeline and checks every distance
// against a predictor of its own or a known value. A short table of
// directed points and radius writes comes first, then random phases. Each
// phase uses fresh radii and a mix of points near the torus, extreme points
// and full-range points. Both sides stall at random.
// ---------------------------------------------------------------------------
module tb_top;

    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int unsigned PHASES       = 7;
    localparam int unsigned PHASE_POINTS = 200;
    localparam int unsigned DRAIN_CYCLES = 80;
    localparam int unsigned PLAN_ROWS    = 24;
    localparam int unsigned ONE          = 65536;

    localparam tsd_pkg::t_cfg_index CFG_RING = tsd_pkg::CFG_RING_RADIUS;
    localparam tsd_pkg::t_cfg_index CFG_TUBE = tsd_pkg::CFG_TUBE_RADIUS;

    logic                                i_clk = 1'b0;
    logic                                i_rst_n = 1'b0;
    logic                                i_valid = 1'b0;
    logic                                o_stall;
    logic signed [tsd_pkg::COORD_W-1:0]  i_pos_x = '0;
    logic signed [tsd_pkg::COORD_W-1:0]  i_pos_y = '0;
    logic signed [tsd_pkg::COORD_W-1:0]  i_pos_z = '0;
    logic                                o_valid;
    logic                                i_stall = 1'b0;
    logic signed [tsd_pkg::DIST_W-1:0]   o_distance;
    logic                                i_cfg_valid = 1'b0;
    logic                                o_cfg_ready;
    logic [tsd_pkg::CFG_IDX_W-1:0]       i_cfg_index = '0;
    logic [tsd_pkg::RADIUS_W-1:0]        i_cfg_data = '0;

    // One row of the directed plan: either a radius write or a point.
    typedef struct packed {
        logic                                is_cfg;
        tsd_pkg::t_cfg_index                 reg_index;
        logic [tsd_pkg::RADIUS_W-1:0]        radius;
        logic signed [tsd_pkg::COORD_W-1:0]  x;
        logic signed [tsd_pkg::COORD_W-1:0]  y;
        logic signed [tsd_pkg::COORD_W-1:0]  z;
        logic                                known;
        logic signed [tsd_pkg::DIST_W-1:0]   want;
    } t_plan_row;

    logic [tsd_pkg::RADIUS_W-1:0]        cur_ring = tsd_pkg::RING_RADIUS_RESET;
    logic [tsd_pkg::RADIUS_W-1:0]        cur_tube = tsd_pkg::TUBE_RADIUS_RESET;
    logic signed [tsd_pkg::DIST_W-1:0]   pending_dist [$];
    int unsigned                         errors = 0;
    int unsigned                         cycle_count = 0;
    logic                                calm;

    // Directed plan. Rows with known set carry a distance that follows
    // directly from the geometry; the rest go through the predictor.
    t_plan_row directed_plan [PLAN_ROWS] = '{
        // Default radii: origin, points on the ring, the z axis.
        '{1'b0, CFG_RING, 31'd0, 32'sd0, 32'sd0, 32'sd0, 1'b1, 32'sd32768},
        '{1'b0, CFG_RING, 31'd0, 32'sd65536, 32'sd0, 32'sd0, 1'b1, -32'sd32768},
        '{1'b0, CFG_RING, 31'd0, 32'sd0, -32'sd65536, 32'sd0, 1'b1, -32'sd32768},
        '{1'b0, CFG_RING, 31'd0, 32'sd0, 32'sd0, 32'sd65536, 1'b0, 32'sd0},
        // Extreme and small coordinates; the first two saturate high.
        '{1'b0, CFG_RING, 31'd0, 32'sh80000000, 32'sh80000000, 32'sh80000000,
          1'b1, 32'sh7fffffff},
        '{1'b0, CFG_RING, 31'd0, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
          1'b1, 32'sh7fffffff},
        '{1'b0, CFG_RING, 31'd0, 32'sd0, 32'sd0, 32'sh80000000, 1'b0, 32'sd0},
        '{1'b0, CFG_RING, 31'd0, 32'sh80000000, 32'sd0, 32'sd0, 1'b0, 32'sd0},
        '{1'b0, CFG_RING, 31'd0, 32'sd1, -32'sd1, -32'sd1, 1'b0, 32'sd0},
        // Zero radii: the origin is at distance zero.
        '{1'b1, CFG_RING, 31'd0, 32'sd0, 32'sd0, 32'sd0, 1'b0, 32'sd0},
        '{1'b1, CFG_TUBE, 31'd0, 32'sd0, 32'sd0, 32'sd0, 1'b0, 32'sd0},
        '{1'b0, CFG_RING, 31'd0, 32'sd0, 32'sd0, 32'sd0, 1'b1, 32'sd0},
        '{1'b0, CFG_RING, 31'd0, 32'sd0, 32'sd0, -32'sd196608, 1'b1, 32'sd196608},
        '{1'b0, CFG_RING, 31'd0, 32'sd196608, 32'sd262144, 32'sd0, 1'b1, 32'sd327680},
        // Largest radii: deepest inside and widest outside.
        '{1'b1, CFG_RING, 31'h7fffffff, 32'sd0, 32'sd0, 32'sd0, 1'b0, 32'sd0},
        '{1'b1, CFG_TUBE, 31'h7fffffff, 32'sd0, 32'sd0, 32'sd0, 1'b0, 32'sd0},
        '{1'b0, CFG_RING, 31'd0, 32'sd0, 32'sd0, 32'sd0, 1'b1, 32'sd0},
        '{1'b0, CFG_RING, 31'd0, 32'sh7fffffff, 32'sd0, 32'sd0, 1'b1, 32'sh80000001},
        '{1'b0, CFG_RING, 31'd0, 32'sh80000000, 32'sh80000000, 32'sh80000000,
          1'b0, 32'sd0},
        '{1'b0, CFG_RING, 31'd0, 32'sd0, 32'sd0, 32'sh7fffffff, 1'b0, 32'sd0},
        // Unit ring with a zero tube: the ring itself is the surface.
        '{1'b1, CFG_RING, 31'd65536, 32'sd0, 32'sd0, 32'sd0, 1'b0, 32'sd0},
        '{1'b1, CFG_TUBE, 31'd0, 32'sd0, 32'sd0, 32'sd0, 1'b0, 32'sd0},
        '{1'b0, CFG_RING, 31'd0, 32'sd65536, 32'sd0, 32'sd0, 1'b1, 32'sd0},
        '{1'b0, CFG_RING, 31'd0, -32'sd65536, 32'sd0, 32'sd32768, 1'b0, 32'sd0}
    };

    torus_signed_distance i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_pos_x     (i_pos_x),
        .i_pos_y     (i_pos_y),
        .i_pos_z     (i_pos_z),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_distance  (o_distance),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // Clock with a 10 ns period.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // A window with no idling on either side.
    assign calm = (cycle_count >= 2000) && (cycle_count < 3500);

    // Cycle counter and run limit.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Random back-pressure on the distance channel.
    always @(posedge i_clk) begin
        i_stall <= !calm && ($urandom_range(0, 99) < 7);
    end

    // Floor of the square root of a 64-bit value, one root bit at a time.
    function automatic logic [31:0] floor_root(input logic [63:0] n);
        logic [31:0] root;
        logic [31:0] trial;
        root = '0;
        for (int b = 31; b >= 0; b--) begin
            trial = root | (32'd1 << b);
            if (64'(trial) * 64'(trial) <= n) begin
                root = trial;
            end
        end
        return root;
    endfunction

    // Signed distance to the torus, with exact wide sums and saturation.
    function automatic logic signed [tsd_pkg::DIST_W-1:0] torus_distance(
        input logic signed [tsd_pkg::COORD_W-1:0] x,
        input logic signed [tsd_pkg::COORD_W-1:0] y,
        input logic signed [tsd_pkg::COORD_W-1:0] z,
        input logic [tsd_pkg::RADIUS_W-1:0]       ring,
        input logic [tsd_pkg::RADIUS_W-1:0]       tube
    );
        longint      sx, sy, sz, q, d;
        logic [63:0] mx, my, mz, mq, plane, sum;
        logic [31:0] r, len;
        sx = x;
        sy = y;
        sz = z;
        mx = (sx < 0) ? -sx : sx;
        my = (sy < 0) ? -sy : sy;
        mz = (sz < 0) ? -sz : sz;
        plane = mx * mx + my * my;
        r = floor_root(plane);
        q = longint'(r) - longint'(ring);
        mq = (q < 0) ? -q : q;
        sum = mq * mq + mz * mz;
        len = floor_root(sum);
        d = longint'(len) - longint'(tube);
        if (d > 64'sd2147483647) begin
            d = 64'sd2147483647;
        end
        if (d < -64'sd2147483648) begin
            d = -64'sd2147483648;
        end
        return d[31:0];
    endfunction

    // Random coordinate: mostly near the torus, some extremes, some full range.
    function automatic logic signed [tsd_pkg::COORD_W-1:0] pick_coord(
        input int unsigned span
    );
        case ($urandom_range(0, 9))
            0, 1: return $urandom;
            2: begin
                case ($urandom_range(0, 4))
                    0: return 32'sh80000000;
                    1: return 32'sh7fffffff;
                    2: return 32'sd0;
                    3: return -32'sd1;
                    default: return 32'sd1;
                endcase
            end
            default: return $urandom_range(0, 2 * span) - span;
        endcase
    endfunction

    // Random radius: zero, largest, a few units, or full range.
    function automatic logic [tsd_pkg::RADIUS_W-1:0] pick_radius();
        logic [31:0] raw;
        case ($urandom_range(0, 5))
            0: raw = '0;
            1: raw = 32'h7fffffff;
            2, 3: raw = $urandom_range(0, 8 * ONE);
            default: raw = $urandom;
        endcase
        return raw[tsd_pkg::RADIUS_W-1:0];
    endfunction

    // Hold the point channel idle until every expected distance has arrived.
    task automatic drain_points();
        i_valid <= 1'b0;
        while (pending_dist.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // Write one radius register while the pipeline is empty.
    task automatic write_radius(
        input tsd_pkg::t_cfg_index          idx,
        input logic [tsd_pkg::RADIUS_W-1:0] value
    );
        drain_points();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == CFG_RING) begin
            cur_ring = value;
        end else begin
            cur_tube = value;
        end
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Send one point; the expected distance is queued once the transaction is taken.
    task automatic push_point(
        input logic signed [tsd_pkg::COORD_W-1:0] x,
        input logic signed [tsd_pkg::COORD_W-1:0] y,
        input logic signed [tsd_pkg::COORD_W-1:0] z,
        input logic                               known,
        input logic signed [tsd_pkg::DIST_W-1:0]  want
    );
        if (!calm && ($urandom_range(0, 99) < 7)) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_pos_x <= x;
        i_pos_y <= y;
        i_pos_z <= z;
        do @(posedge i_clk); while (o_stall);
        pending_dist.push_back(known ? want : torus_distance(x, y, z, cur_ring, cur_tube));
    endtask

    // Compare each distance transaction with the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_dist.size() == 0) begin
                $display("%0t: unexpected distance %0d, none expected", $time, o_distance);
                errors <= errors + 1;
            end else begin
                if (o_distance !== pending_dist[0]) begin
                    $display("%0t: distance mismatch, expected %0d, actual %0d",
                             $time, pending_dist[0], o_distance);
                    errors <= errors + 1;
                end
                void'(pending_dist.pop_front());
            end
        end
    end

    // Stimulus: reset, directed plan, then random phases.
    initial begin
        int unsigned span;
        longint      wide_span;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_plan[k]) begin
            if (directed_plan[k].is_cfg) begin
                write_radius(directed_plan[k].reg_index, directed_plan[k].radius);
            end else begin
                push_point(directed_plan[k].x, directed_plan[k].y, directed_plan[k].z,
                           directed_plan[k].known, directed_plan[k].want);
            end
        end

        for (int p = 0; p < PHASES; p++) begin
            write_radius(CFG_RING, pick_radius());
            write_radius(CFG_TUBE, pick_radius());
            // Keep most points inside a box two units past the outer radius, capped at 2^30.
            wide_span = longint'(cur_ring) + longint'(cur_tube) + 2 * ONE;
            span = (wide_span > 64'sd1073741824) ? 32'd1073741824 : wide_span[31:0];
            repeat (PHASE_POINTS) begin
                push_point(pick_coord(span), pick_coord(span), pick_coord(span), 1'b0, '0);
            end
        end

        drain_points();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/tsd_pkg.sv
rtl/tsd_root_cell.sv
rtl/tsd_root_chain.sv
rtl/torus_signed_distance.sv
tb/sv/tb_top.sv
